FILE: rtl/sha1md_pkg.sv
// ============================================================================
// SHA-1 message digest: shared package
// Types, constants and helper functions used by the controller, the
// datapath and the top level.
// ============================================================================
`default_nettype none

package sha1md_pkg;

  // Block geometry and round count.
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned BLOCK_BITS  = BLOCK_BYTES * 8;
  localparam int unsigned ROUNDS      = 80;
  localparam int unsigned WORDS       = 5;
  localparam int unsigned COUNT_W     = 61;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned RND_W       = 7;
  localparam int unsigned WIDX_W      = 3;

  // Byte position at which the 64-bit length field starts.
  localparam logic [POS_W-1:0] LEN_POS  = POS_W'(56);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(63);

  // Pad marker byte.
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Initial chaining values h0 to h4.
  localparam logic [31:0] H_INIT [WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  // Datapath operations.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_DATA,
    OP_PAD80,
    OP_ZERO,
    OP_LEN,
    OP_ROUND,
    OP_UPDATE,
    OP_CLEAR
  } dp_op_t;

  // Command bundle from the controller to the datapath.
  typedef struct packed {
    dp_op_t            op;
    logic              load_work;  // copy chaining words into a..e
    logic [1:0]        phase;      // round group, 20 rounds each
    logic [2:0]        len_idx;    // which length byte, 0 is most significant
    logic [WIDX_W-1:0] widx;       // chaining word shown on the output
  } dp_cmd_t;

  // Status bundle from the datapath to the controller.
  typedef struct packed {
    logic pos_last;  // next byte fills the last slot of the block
    logic pos_len;   // next byte would be the first length byte
  } dp_sts_t;

  // Round constant for each group of 20 rounds.
  function automatic logic [31:0] round_k(input logic [1:0] phase);
    logic [31:0] k;
    case (phase)
      2'd0:    k = 32'h5a827999;
      2'd1:    k = 32'h6ed9eba1;
      2'd2:    k = 32'h8f1bbcdc;
      default: k = 32'hca62c1d6;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sha1md_ctrl.sv
// ============================================================================
// SHA-1 message digest: controller
// Sequences byte intake, padding, the 80 compression rounds, the chaining
// update and the five output transfers.
// ============================================================================
`default_nettype none

module sha1md_ctrl
  import sha1md_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic              in_tuser,
  input  wire logic              in_tlast,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [WIDX_W-1:0]      out_tuser,
  output logic                   out_tlast,
  output dp_cmd_t                cmd,
  input  wire dp_sts_t           sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_PADZ,
    ST_LEN,
    ST_COMP,
    ST_UPD,
    ST_OUT
  } state_t;

  state_t            state_r, state_nxt;
  state_t            ret_r, ret_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt;
  logic [2:0]        len_idx_r, len_idx_nxt;
  logic [WIDX_W-1:0] widx_r, widx_nxt;

  // Next-state and command decode.
  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    rnd_nxt        = rnd_r;
    len_idx_nxt    = len_idx_r;
    widx_nxt       = widx_r;
    cmd.op         = OP_NOP;
    cmd.load_work  = 1'b0;
    cmd.len_idx    = len_idx_r;
    cmd.widx       = widx_r;
    if (rnd_r < RND_W'(20)) begin
      cmd.phase = 2'd0;
    end else if (rnd_r < RND_W'(40)) begin
      cmd.phase = 2'd1;
    end else if (rnd_r < RND_W'(60)) begin
      cmd.phase = 2'd2;
    end else begin
      cmd.phase = 2'd3;
    end
    in_tready      = 1'b0;
    out_tvalid     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser) begin
            cmd.op = OP_DATA;
            if (sts.pos_last) begin
              // Block is full: compress, then pad if the message ends here.
              cmd.load_work = 1'b1;
              rnd_nxt       = '0;
              state_nxt     = ST_COMP;
              ret_nxt       = in_tlast ? ST_PAD80 : ST_IDLE;
            end else if (in_tlast) begin
              state_nxt = ST_PAD80;
            end
          end else if (in_tlast) begin
            state_nxt = ST_PAD80;
          end
        end
      end
      ST_PAD80: begin
        cmd.op = OP_PAD80;
        if (sts.pos_last) begin
          cmd.load_work = 1'b1;
          rnd_nxt       = '0;
          state_nxt     = ST_COMP;
          ret_nxt       = ST_PADZ;
        end else begin
          state_nxt = ST_PADZ;
        end
      end
      ST_PADZ: begin
        // Zero fill up to the length field, compressing on a block wrap.
        if (sts.pos_len) begin
          len_idx_nxt = '0;
          state_nxt   = ST_LEN;
        end else begin
          cmd.op = OP_ZERO;
          if (sts.pos_last) begin
            cmd.load_work = 1'b1;
            rnd_nxt       = '0;
            state_nxt     = ST_COMP;
            ret_nxt       = ST_PADZ;
          end
        end
      end
      ST_LEN: begin
        cmd.op = OP_LEN;
        if (len_idx_r == 3'd7) begin
          cmd.load_work = 1'b1;
          rnd_nxt       = '0;
          state_nxt     = ST_COMP;
          ret_nxt       = ST_OUT;
        end else begin
          len_idx_nxt = len_idx_r + 3'd1;
        end
      end
      ST_COMP: begin
        cmd.op = OP_ROUND;
        if (rnd_r == RND_W'(ROUNDS - 1)) begin
          state_nxt = ST_UPD;
        end else begin
          rnd_nxt = rnd_r + RND_W'(1);
        end
      end
      ST_UPD: begin
        cmd.op    = OP_UPDATE;
        widx_nxt  = '0;
        state_nxt = ret_r;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (widx_r == WIDX_W'(WORDS - 1)) begin
            // Digest delivered: return to the initial chaining values.
            cmd.op    = OP_CLEAR;
            widx_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            widx_nxt = widx_r + WIDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tuser = widx_r;
  assign out_tlast = (state_r == ST_OUT) && (widx_r == WIDX_W'(WORDS - 1));

  // State and sequencing counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ret_r     <= ST_IDLE;
      rnd_r     <= '0;
      len_idx_r <= '0;
      widx_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      rnd_r     <= rnd_nxt;
      len_idx_r <= len_idx_nxt;
      widx_r    <= widx_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sha1md_dp.sv
// ============================================================================
// SHA-1 message digest: datapath
// Block shift register holding the 16-word schedule window, the working
// variables a..e, the chaining words and the byte counters.
// ============================================================================
`default_nettype none

module sha1md_dp
  import sha1md_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  byte_in,
  input  wire dp_cmd_t     cmd,
  output dp_sts_t          sts,
  output logic [31:0]      digest_word
);

  logic [BLOCK_BITS-1:0] blk_r, blk_nxt;
  logic [31:0]           a_r, b_r, c_r, d_r, e_r;
  logic [31:0]           a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0]           h_r [WORDS];
  logic [31:0]           h_nxt [WORDS];
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;

  logic [63:0]           bit_len;
  logic [2:0]            len_shift;
  logic [7:0]            len_byte;
  logic [7:0]            shift_byte;
  logic                  do_shift;
  logic [31:0]           w0, w2, w8, w13, w_new;
  logic [31:0]           f_val, t_val;

  // Length field bytes, most significant first.
  assign bit_len   = {count_r, 3'b000};
  assign len_shift = 3'd7 - cmd.len_idx;
  assign len_byte  = bit_len[{len_shift, 3'b000} +: 8];

  // Byte that enters the block on a shift.
  always_comb begin
    case (cmd.op)
      OP_DATA:  shift_byte = byte_in;
      OP_PAD80: shift_byte = PAD_BYTE;
      OP_LEN:   shift_byte = len_byte;
      default:  shift_byte = 8'h00;
    endcase
  end
  assign do_shift = (cmd.op == OP_DATA) || (cmd.op == OP_PAD80) ||
                    (cmd.op == OP_ZERO) || (cmd.op == OP_LEN);

  // Schedule window taps; word 0 sits in the top bits.
  assign w0    = blk_r[BLOCK_BITS-1 -: 32];
  assign w2    = blk_r[BLOCK_BITS-1-2*32 -: 32];
  assign w8    = blk_r[BLOCK_BITS-1-8*32 -: 32];
  assign w13   = blk_r[BLOCK_BITS-1-13*32 -: 32];
  assign w_new = {w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0],
                  w13[31] ^ w8[31] ^ w2[31] ^ w0[31]};

  // Round function.
  always_comb begin
    case (cmd.phase)
      2'd0:    f_val = (b_r & c_r) | (~b_r & d_r);
      2'd2:    f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      default: f_val = b_r ^ c_r ^ d_r;
    endcase
  end
  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + round_k(cmd.phase) + w0;

  // Next values.
  always_comb begin
    blk_nxt   = blk_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    e_nxt     = e_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    for (int i = 0; i < WORDS; i++) begin
      h_nxt[i] = h_r[i];
    end

    if (do_shift) begin
      blk_nxt = {blk_r[BLOCK_BITS-9:0], shift_byte};
      pos_nxt = pos_r + POS_W'(1);
    end
    if (cmd.op == OP_DATA) begin
      count_nxt = count_r + COUNT_W'(1);
    end
    if (cmd.load_work) begin
      a_nxt = h_r[0];
      b_nxt = h_r[1];
      c_nxt = h_r[2];
      d_nxt = h_r[3];
      e_nxt = h_r[4];
    end

    case (cmd.op)
      OP_ROUND: begin
        blk_nxt = {blk_r[BLOCK_BITS-33:0], w_new};
        a_nxt   = t_val;
        b_nxt   = a_r;
        c_nxt   = {b_r[1:0], b_r[31:2]};
        d_nxt   = c_r;
        e_nxt   = d_r;
      end
      OP_UPDATE: begin
        h_nxt[0] = h_r[0] + a_r;
        h_nxt[1] = h_r[1] + b_r;
        h_nxt[2] = h_r[2] + c_r;
        h_nxt[3] = h_r[3] + d_r;
        h_nxt[4] = h_r[4] + e_r;
      end
      OP_CLEAR: begin
        for (int i = 0; i < WORDS; i++) begin
          h_nxt[i] = H_INIT[i];
        end
        count_nxt = '0;
        pos_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WORDS; i++) begin
        h_r[i] <= H_INIT[i];
      end
      count_r <= '0;
      pos_r   <= '0;
    end else begin
      for (int i = 0; i < WORDS; i++) begin
        h_r[i] <= h_nxt[i];
      end
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
  end

  assign sts.pos_last = (pos_r == LAST_POS);
  assign sts.pos_len  = (pos_r == LEN_POS);

  // Output word select.
  always_comb begin
    case (cmd.widx)
      3'd0:    digest_word = h_r[0];
      3'd1:    digest_word = h_r[1];
      3'd2:    digest_word = h_r[2];
      3'd3:    digest_word = h_r[3];
      3'd4:    digest_word = h_r[4];
      default: digest_word = h_r[4];
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/sha1_message_digest.sv
// ============================================================================
// SHA-1 message digest: top level
// Byte-stream SHA-1 hash with a controller and a round datapath.
// ============================================================================
// The message arrives on the in_ stream one byte per transfer: in_tdata is
// the byte, in_tuser says a byte is present and in_tlast closes the message.
// A transfer with in_tlast and no byte closes the message with the bytes
// seen so far (the empty message if none).
// The transfer that fills a 64-byte block starts the 80 rounds, one per
// cycle, and then the chaining update.
// On in_tlast the pad byte, zero fill and length are shifted in byte by
// byte (up to 72 bytes), with one or two further compressions.
// The digest then leaves on the out_ stream as five transfers: out_tdata
// is the word, out_tuser its index (0 is h0) and out_tlast marks h4.
// A message byte is taken at most every cycle; throughput over a long
// message is bounded by the single round unit.
// in_tready is low while a block compresses, padding runs or the digest
// waits; a stalled word is held until the receiver takes it.
// After the fifth word the chaining words return to the initial constants.
// Synchronous reset loads the initial constants and clears the byte count.
// ============================================================================
`default_nettype none

module sha1_message_digest
  import sha1md_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // [7:0] byte_value
  input  wire logic              in_tuser,   // [0] byte_present
  input  wire logic              in_tlast,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [31:0]            out_tdata,  // [31:0] digest_word
  output logic [WIDX_W-1:0]      out_tuser,  // [2:0] word_index
  output logic                   out_tlast
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sha1md_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

  sha1md_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_in     (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .digest_word (out_tdata)
  );

endmodule

`default_nettype wire

FILE: rtl/sha1md_chk.sv
// ============================================================================
// SHA-1 message digest: port checker
// Checks output sequencing and stall behavior seen at the top-level ports.
// ============================================================================
`default_nettype none

module sha1md_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [2:0]  out_tuser,
  input wire logic        out_tlast
);

  // A stalled output word holds its value and index.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

  // Input is never taken while the digest is being delivered.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready during digest output");

  // The last flag marks exactly the word with index four.
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == 3'd4)))
    else $error("last flag does not match word index");

  // Words follow in index order without gaps.
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tuser == $past(out_tuser) + 3'd1))
    else $error("digest words out of order");

  // After the last word the block returns to taking input.
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid && in_tready)
    else $error("block did not return to input after digest");

endmodule

bind sha1_message_digest sha1md_chk u_sha1md_chk (.*);

`default_nettype wire
